### rtl/core/hbma_pkg.sv
// Shared types, constants and microcode ROM for the heart beat monitor alarm.
// No dependencies; used by hbma_seq, hbma_dp and heart_beat_monitor_alarm.
`timescale 1ns / 1ps

package hbma_pkg;

	localparam int SAMPLE_BITS = 10;
	localparam int TIME_BITS   = 32;
	localparam int LEVEL_BITS  = 8;
	localparam int BPM_BITS    = 16;
	localparam int CFG_BITS    = 16;
	localparam int INDEX_BITS  = 3;
	localparam int STEP_BITS   = 3;
	localparam int DIV_CNT_BITS = 4;

	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
	localparam logic [BPM_BITS-1:0]    BPM_NUMER  = 16'd60000;
	localparam logic [BPM_BITS-1:0]    FAST_BPM   = 16'd160;
	localparam logic [BPM_BITS-1:0]    SLOW_HI    = 16'd40;
	localparam logic [BPM_BITS-1:0]    SLOW_LO    = 16'd30;
	localparam logic [BPM_BITS-1:0]    VSLOW_LO   = 16'd10;

	// alarm register bit positions
	localparam int ALM_FAST  = 0;
	localparam int ALM_SLOW  = 1;
	localparam int ALM_VSLOW = 2;
	localparam int ALM_SHOCK = 3;

	localparam logic [7:0]  RST_LOW_THR   = 8'd140;
	localparam logic [7:0]  RST_HIGH_THR  = 8'd150;
	localparam logic [15:0] RST_NO_BEAT   = 16'd10000;
	localparam logic [15:0] RST_RELEASE   = 16'd15000;
	localparam logic [15:0] RST_HOLD      = 16'd5000;

	typedef enum logic [INDEX_BITS-1:0] {
		REG_LOW_THR   = 3'd0,
		REG_HIGH_THR  = 3'd1,
		REG_NO_BEAT   = 3'd2,
		REG_RELEASE   = 3'd3,
		REG_HOLD      = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] raw_sample;
		logic [TIME_BITS-1:0]   now_ms;
	} in_word_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] level;
		logic                  beat;
		logic [BPM_BITS-1:0]   rate_bpm;
		logic                  fast_alarm;
		logic                  slow_alarm;
		logic                  very_slow_alarm;
		logic                  shock;
		logic                  zero_interval;
	} out_word_t;

	typedef enum logic [3:0] {
		OP_LOAD    = 4'd0,
		OP_DETECT  = 4'd1,
		OP_DIV     = 4'd2,
		OP_BEAT    = 4'd3,
		OP_FIRE    = 4'd4,
		OP_RELEASE = 4'd5,
		OP_HOLD    = 4'd6,
		OP_EMIT    = 4'd7
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER    = 3'd0,
		COND_NO_VALID = 3'd1,
		COND_NO_BEAT  = 3'd2,
		COND_DIV_MORE = 3'd3,
		COND_OUT_BUSY = 3'd4
	} cond_t;

	typedef logic [STEP_BITS-1:0] step_t;

	localparam step_t STEP_LOAD = 3'd0;
	localparam step_t STEP_DIV  = 3'd2;
	localparam step_t STEP_FIRE = 3'd4;
	localparam step_t STEP_EMIT = 3'd7;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
		logic  done;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic beat;
		logic div_more;
		logic out_busy;
	} status_t;

	// microcode: one control word per step
	function automatic ctrl_t ucode(input step_t s);
		ctrl_t w;
		w = '{op: OP_LOAD, cond: COND_NEVER, target: STEP_LOAD, done: 1'b0};
		case (s)
			3'd0: w = '{op: OP_LOAD,    cond: COND_NO_VALID, target: STEP_LOAD, done: 1'b0};
			3'd1: w = '{op: OP_DETECT,  cond: COND_NO_BEAT,  target: STEP_FIRE, done: 1'b0};
			3'd2: w = '{op: OP_DIV,     cond: COND_DIV_MORE, target: STEP_DIV,  done: 1'b0};
			3'd3: w = '{op: OP_BEAT,    cond: COND_NEVER,    target: STEP_LOAD, done: 1'b0};
			3'd4: w = '{op: OP_FIRE,    cond: COND_NEVER,    target: STEP_LOAD, done: 1'b0};
			3'd5: w = '{op: OP_RELEASE, cond: COND_NEVER,    target: STEP_LOAD, done: 1'b0};
			3'd6: w = '{op: OP_HOLD,    cond: COND_NEVER,    target: STEP_LOAD, done: 1'b0};
			3'd7: w = '{op: OP_EMIT,    cond: COND_OUT_BUSY, target: STEP_EMIT, done: 1'b1};
			default: w = '{op: OP_LOAD, cond: COND_NEVER, target: STEP_LOAD, done: 1'b0};
		endcase
		return w;
	endfunction

endpackage

### rtl/core/hbma_seq.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on hbma_pkg.
`timescale 1ns / 1ps

module hbma_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  hbma_pkg::status_t st,
	output hbma_pkg::ctrl_t   ctrl
);
	import hbma_pkg::*;

	step_t upc_q;
	logic  jump;

	assign ctrl = ucode(upc_q);

	always_comb begin
		case (ctrl.cond)
			COND_NEVER:    jump = 1'b0;
			COND_NO_VALID: jump = !st.in_valid;
			COND_NO_BEAT:  jump = !st.beat;
			COND_DIV_MORE: jump = st.div_more;
			COND_OUT_BUSY: jump = st.out_busy;
			default:       jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= STEP_LOAD;
		end else if (jump) begin
			upc_q <= ctrl.target;
		end else if (ctrl.done) begin
			upc_q <= STEP_LOAD;
		end else begin
			upc_q <= upc_q + step_t'(1);
		end
	end

endmodule

### rtl/core/hbma_dp.sv
// Datapath: config registers, level scaling, beat detector, serial bpm
// divider, alarm/shock state and output register. Depends on hbma_pkg.
`timescale 1ns / 1ps

module hbma_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  hbma_pkg::ctrl_t                      ctrl,
	output hbma_pkg::status_t                    st,
	input  logic                                 in_valid,
	input  hbma_pkg::in_word_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output hbma_pkg::out_word_t                  out_data,
	input  logic                                 cfg_we,
	input  logic [hbma_pkg::INDEX_BITS-1:0]      cfg_index,
	input  logic [hbma_pkg::CFG_BITS-1:0]        cfg_data
);
	import hbma_pkg::*;

	localparam int PROD_BITS = SAMPLE_BITS + 8;

	// config
	logic [7:0]  low_thr_q, high_thr_q;
	logic [15:0] no_beat_q, release_q, hold_q;

	// sample and working registers
	logic [SAMPLE_BITS-1:0]  raw_q;
	logic [TIME_BITS-1:0]    now_q;
	logic [LEVEL_BITS-1:0]   level_q;
	logic                    beat_q, zero_q;
	logic [TIME_BITS-1:0]    dt_q;
	logic [BPM_BITS-1:0]     rem_q, quo_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;

	// monitor state
	logic                    armed_q, shock_q;
	logic [TIME_BITS-1:0]    last_beat_q, shock_start_q;
	logic [BPM_BITS-1:0]     bpm_q;
	logic [3:0]              alarm_q;

	out_word_t out_q;
	logic      out_valid_q;

	// level = raw*255 / (2^n-1): split at bit n, one correction step
	logic [PROD_BITS-1:0]    prod;
	logic [7:0]              q0;
	logic [SAMPLE_BITS:0]    r0;
	logic [LEVEL_BITS-1:0]   level;
	logic                    beat_now;

	assign prod  = {raw_q, 8'd0} - PROD_BITS'(raw_q);
	assign q0    = prod[PROD_BITS-1:SAMPLE_BITS];
	assign r0    = {3'd0, q0} + {1'b0, prod[SAMPLE_BITS-1:0]};
	assign level = q0 + LEVEL_BITS'(r0 >= {1'b0, SAMPLE_MAX});
	assign beat_now = (level > high_thr_q) && !armed_q;

	logic [TIME_BITS-1:0] since_beat, since_shock;
	assign since_beat  = now_q - last_beat_q;
	assign since_shock = now_q - shock_start_q;

	// restoring divider step
	logic [BPM_BITS:0]    rem_sh;
	logic                 ge;
	assign rem_sh = {rem_q, BPM_NUMER[cnt_q]};
	assign ge     = TIME_BITS'(rem_sh) >= dt_q;

	logic [BPM_BITS-1:0] bpm_new;
	assign bpm_new = (dt_q == '0) ? BPM_NUMER : quo_q;

	logic emit;
	assign emit = (ctrl.op == OP_EMIT) && !(out_valid_q && out_stall);

	assign st.in_valid = in_valid;
	assign st.beat     = beat_now;
	assign st.div_more = (cnt_q != '0);
	assign st.out_busy = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_thr_q  <= RST_LOW_THR;
			high_thr_q <= RST_HIGH_THR;
			no_beat_q  <= RST_NO_BEAT;
			release_q  <= RST_RELEASE;
			hold_q     <= RST_HOLD;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOW_THR:  low_thr_q  <= cfg_data[7:0];
				REG_HIGH_THR: high_thr_q <= cfg_data[7:0];
				REG_NO_BEAT:  no_beat_q  <= cfg_data;
				REG_RELEASE:  release_q  <= cfg_data;
				REG_HOLD:     hold_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// payload and divider working registers, and the output word register
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				if (in_valid) begin
					raw_q <= in_data.raw_sample;
					now_q <= in_data.now_ms;
				end
			end
			OP_DETECT: begin
				level_q <= level;
				beat_q  <= beat_now;
				zero_q  <= 1'b0;
				dt_q    <= since_beat;
				rem_q   <= '0;
				quo_q   <= '0;
				cnt_q   <= '1;
			end
			OP_DIV: begin
				rem_q <= ge ? BPM_BITS'(rem_sh - dt_q[BPM_BITS:0]) : rem_sh[BPM_BITS-1:0];
				quo_q <= {quo_q[BPM_BITS-2:0], ge};
				cnt_q <= cnt_q - DIV_CNT_BITS'(1);
			end
			OP_BEAT: begin
				zero_q <= (dt_q == '0);
			end
			default: ;
		endcase
		if (emit) begin
			out_q.level           <= level_q;
			out_q.beat            <= beat_q;
			out_q.rate_bpm        <= bpm_q;
			out_q.fast_alarm      <= alarm_q[ALM_FAST];
			out_q.slow_alarm      <= alarm_q[ALM_SLOW];
			out_q.very_slow_alarm <= alarm_q[ALM_VSLOW];
			out_q.shock           <= alarm_q[ALM_SHOCK];
			out_q.zero_interval   <= zero_q;
		end
	end

	// monitor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q       <= 1'b0;
			shock_q       <= 1'b0;
			last_beat_q   <= '0;
			shock_start_q <= '0;
			bpm_q         <= '0;
			alarm_q       <= '0;
		end else begin
			case (ctrl.op)
				OP_DETECT: begin
					// beat test first, then re-arm on the same sample
					if (level < low_thr_q && (beat_now || armed_q))
						armed_q <= 1'b0;
					else if (beat_now)
						armed_q <= 1'b1;
				end
				OP_BEAT: begin
					bpm_q       <= bpm_new;
					last_beat_q <= now_q;
					alarm_q[ALM_FAST]  <= bpm_new > FAST_BPM;
					alarm_q[ALM_SLOW]  <= (bpm_new > SLOW_LO) && (bpm_new < SLOW_HI);
					alarm_q[ALM_VSLOW] <= (bpm_new > VSLOW_LO) && (bpm_new < SLOW_LO);
				end
				OP_FIRE: begin
					if (since_beat >= TIME_BITS'(no_beat_q) && !shock_q) begin
						alarm_q       <= 4'b1 << ALM_SHOCK;
						shock_q       <= 1'b1;
						shock_start_q <= now_q;
						bpm_q         <= '0;
					end
				end
				OP_RELEASE: begin
					if (since_beat >= TIME_BITS'(release_q) && shock_q) begin
						alarm_q       <= '0;
						shock_q       <= 1'b0;
						shock_start_q <= '0;
						last_beat_q   <= now_q;
					end
				end
				OP_HOLD: begin
					if (since_shock >= TIME_BITS'(hold_q) && shock_q && bpm_q != '0) begin
						alarm_q[ALM_SHOCK] <= 1'b0;
						shock_q            <= 1'b0;
						shock_start_q      <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

### rtl/core/heart_beat_monitor_alarm.sv
// Heart beat monitor alarm: one result word per ECG sample word. A sample
// is taken when the sequencer is at its load step; a sample without a beat
// then passes the detect, fire, release, hold and emit steps; one with a beat
// also passes the beat step and the one-bit-per-cycle restoring divider
// that forms 60000 / interval. The result sits in an output register, so
// the next sample is accepted while it waits; the emit step holds only if
// a previous result is still unread. Config writes are taken at any time
// but are meant for idle periods. Depends on hbma_pkg, hbma_seq, hbma_dp.
`timescale 1ns / 1ps

module heart_beat_monitor_alarm (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  hbma_pkg::in_word_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output hbma_pkg::out_word_t             out_data,
	input  logic                            cfg_we,
	input  logic [hbma_pkg::INDEX_BITS-1:0] cfg_index,
	input  logic [hbma_pkg::CFG_BITS-1:0]   cfg_data
);
	import hbma_pkg::*;

	ctrl_t   ctrl;
	status_t st;

	assign in_stall = (ctrl.op != OP_LOAD);

	hbma_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.ctrl   (ctrl)
	);

	hbma_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.st        (st),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
